// ===== sv/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types and codes of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int POS_BITS = 24;
  localparam int FIELD_W  = 24;

  localparam logic [1:0] K_TOKEN = 2'd0;
  localparam logic [1:0] K_CHAR  = 2'd1;
  localparam logic [1:0] K_ERROR = 2'd2;
  localparam logic [1:0] K_END   = 2'd3;

  localparam logic [4:0] T_IDENT  = 5'd7;
  localparam logic [4:0] T_INT    = 5'd8;
  localparam logic [4:0] T_FLOAT  = 5'd9;
  localparam logic [4:0] T_STRING = 5'd10;
  localparam logic [4:0] T_DIV    = 5'd22;
  localparam logic [4:0] T_DOT    = 5'd24;
  localparam logic [4:0] T_COL    = 5'd25;
  localparam logic [4:0] T_DCOL   = 5'd26;
  localparam logic [4:0] T_NONE   = 5'd0;

  localparam logic [1:0] E_UNRECOG = 2'd0;
  localparam logic [1:0] E_UNTERM  = 2'd1;
  localparam logic [1:0] E_TOOLONG = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         token_type;
    logic [FIELD_W-1:0] start_pos;
    logic [FIELD_W-1:0] length;
    logic [7:0]         char_value;
    logic [1:0]         error_code;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [1:0]       n;
    out_t [2:0]       items;
  } res_t;

endpackage

// ===== sv/stok_lexer.sv =====
// ----------------------------------------------------------------------------
// stok_lexer
// Lexer state and the per-byte step that forms up to three results.
// ----------------------------------------------------------------------------
module stok_lexer import stok_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic acc_i,
  input  in_t  in_i,
  output res_t res_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_IDENT, M_INT,
    M_INTDOT, M_FLOAT, M_STR, M_ESC, M_COLON, M_ERROR
  } mode_e;

  localparam logic [71:0] KW_STR [7] = '{"if", "else", "for", "while",
                                          "namespace", "fn", "return"};
  localparam logic [3:0]  KW_LEN [7] = '{4'd2, 4'd4, 4'd3, 4'd5, 4'd9, 4'd2, 4'd6};

  mode_e               mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d, start_q, start_d, len;
  logic [6:0]          alive_q, alive_d;
  logic [3:0]          idx;
  logic [4:0]          id_type, pc;
  out_t [2:0]          r;
  logic [1:0]          n;
  logic                go;
  logic [7:0]          c;

  function automatic out_t mk(logic [1:0] k, logic [4:0] t, logic [FIELD_W-1:0] s,
                              logic [FIELD_W-1:0] l, logic [7:0] v, logic [1:0] e);
    out_t o;
    o.kind = k; o.token_type = t; o.start_pos = s; o.length = l;
    o.char_value = v; o.error_code = e; o.last = 1'b0;
    return o;
  endfunction

  function automatic logic [6:0] kw_next(logic [6:0] a, logic [7:0] ch, logic [3:0] j);
    logic [6:0] m;
    m = a;
    for (int k = 0; k < 7; k++) begin
      if (a[k]) begin
        if (j >= KW_LEN[k]) m[k] = 1'b0;
        else if (KW_STR[k][8*(KW_LEN[k]-1-j) +: 8] != ch) m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [4:0] punct(logic [7:0] ch);
    logic [4:0] t;
    unique case (ch)
      "(": t = 5'd11;
      ")": t = 5'd12;
      "{": t = 5'd13;
      "}": t = 5'd14;
      "[": t = 5'd15;
      "]": t = 5'd16;
      ",": t = 5'd17;
      "=": t = 5'd18;
      "+": t = 5'd19;
      "-": t = 5'd20;
      "*": t = 5'd21;
      "/": t = 5'd22;
      "^": t = 5'd23;
      ".": t = 5'd24;
      default: t = T_NONE;
    endcase
    return t;
  endfunction

  function automatic logic is_alpha(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  assign c   = in_i.ch;
  assign len = pos_q - start_q;
  assign idx = (len > POS_BITS'(8)) ? 4'hF : len[3:0];
  assign pc  = punct(c);

  always_comb begin
    id_type = T_IDENT;
    for (int k = 6; k >= 0; k--) begin
      if (alive_q[k] && len == POS_BITS'(KW_LEN[k])) id_type = 5'(k);
    end
  end

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    alive_d = alive_q;
    r       = '0;
    n       = 2'd0;
    go      = 1'b0;
    if (in_i.end_of_text) begin
      case (mode_q)
        M_SLASH: begin
          r[n] = mk(K_TOKEN, T_DIV, FIELD_W'(start_q), FIELD_W'(1), 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_IDENT: begin
          r[n] = mk(K_TOKEN, id_type, FIELD_W'(start_q), FIELD_W'(len), 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_INT: begin
          r[n] = mk(K_TOKEN, T_INT, FIELD_W'(start_q), FIELD_W'(len), 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_FLOAT: begin
          r[n] = mk(K_TOKEN, T_FLOAT, FIELD_W'(start_q), FIELD_W'(len), 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_INTDOT: begin
          r[n] = mk(K_TOKEN, T_INT, FIELD_W'(start_q),
                    FIELD_W'(len - POS_BITS'(1)), 8'd0, 2'd0);
          n = n + 2'd1;
          r[n] = mk(K_TOKEN, T_DOT, FIELD_W'(pos_q - POS_BITS'(1)), FIELD_W'(1),
                    8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_COLON: begin
          r[n] = mk(K_TOKEN, T_COL, FIELD_W'(start_q), FIELD_W'(1), 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_STR, M_ESC: begin
          r[n] = mk(K_ERROR, T_NONE, FIELD_W'(start_q), FIELD_W'(len), 8'd0, E_UNTERM);
          n = n + 2'd1;
        end
        default: ;
      endcase
      r[n] = mk(K_END, T_NONE, '0, '0, 8'd0, 2'd0);
      n = n + 2'd1;
      mode_d  = M_IDLE;
      pos_d   = '0;
      start_d = '0;
      alive_d = '0;
    end else if (mode_q != M_ERROR) begin
      if (pos_q == '1) begin
        r[n] = mk(K_ERROR, T_NONE, FIELD_W'(pos_q), '0, 8'd0, E_TOOLONG);
        n = n + 2'd1;
        mode_d = M_ERROR;
      end else begin
        pos_d = pos_q + POS_BITS'(1);
        case (mode_q)
          M_SLASH: begin
            if (c == "/") mode_d = M_LINE;
            else if (c == "*") mode_d = M_BLOCK;
            else begin
              r[n] = mk(K_TOKEN, T_DIV, FIELD_W'(start_q), FIELD_W'(1), 8'd0, 2'd0);
              n = n + 2'd1;
              go = 1'b1;
            end
          end
          M_LINE:  if (c == 8'h0A) mode_d = M_IDLE;
          M_BLOCK: if (c == "*") mode_d = M_BSTAR;
          M_BSTAR: begin
            if (c == "/") mode_d = M_IDLE;
            else if (c != "*") mode_d = M_BLOCK;
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_") alive_d = kw_next(alive_q, c, idx);
            else begin
              r[n] = mk(K_TOKEN, id_type, FIELD_W'(start_q), FIELD_W'(len), 8'd0, 2'd0);
              n = n + 2'd1;
              go = 1'b1;
            end
          end
          M_INT: begin
            if (c == ".") mode_d = M_INTDOT;
            else if (!is_digit(c)) begin
              r[n] = mk(K_TOKEN, T_INT, FIELD_W'(start_q), FIELD_W'(len), 8'd0, 2'd0);
              n = n + 2'd1;
              go = 1'b1;
            end
          end
          M_INTDOT: begin
            if (is_digit(c)) mode_d = M_FLOAT;
            else begin
              r[n] = mk(K_TOKEN, T_INT, FIELD_W'(start_q),
                        FIELD_W'(len - POS_BITS'(1)), 8'd0, 2'd0);
              n = n + 2'd1;
              r[n] = mk(K_TOKEN, T_DOT, FIELD_W'(pos_q - POS_BITS'(1)), FIELD_W'(1),
                        8'd0, 2'd0);
              n = n + 2'd1;
              go = 1'b1;
            end
          end
          M_FLOAT: begin
            if (!is_digit(c)) begin
              r[n] = mk(K_TOKEN, T_FLOAT, FIELD_W'(start_q), FIELD_W'(len), 8'd0, 2'd0);
              n = n + 2'd1;
              go = 1'b1;
            end
          end
          M_STR: begin
            if (c == "\"") begin
              r[n] = mk(K_TOKEN, T_STRING, FIELD_W'(start_q),
                        FIELD_W'(len + POS_BITS'(1)), 8'd0, 2'd0);
              n = n + 2'd1;
              mode_d = M_IDLE;
            end else if (c == "\\") mode_d = M_ESC;
            else begin
              r[n] = mk(K_CHAR, T_NONE, '0, '0, c, 2'd0);
              n = n + 2'd1;
            end
          end
          M_ESC: begin
            if (c == "n") begin
              r[n] = mk(K_CHAR, T_NONE, '0, '0, 8'h0A, 2'd0);
              n = n + 2'd1;
            end else if (c == "t") begin
              r[n] = mk(K_CHAR, T_NONE, '0, '0, 8'h09, 2'd0);
              n = n + 2'd1;
            end else if (c == "\"" || c == "\\") begin
              r[n] = mk(K_CHAR, T_NONE, '0, '0, c, 2'd0);
              n = n + 2'd1;
            end else begin
              r[n] = mk(K_CHAR, T_NONE, '0, '0, "\\", 2'd0);
              n = n + 2'd1;
              r[n] = mk(K_CHAR, T_NONE, '0, '0, c, 2'd0);
              n = n + 2'd1;
            end
            mode_d = M_STR;
          end
          M_COLON: begin
            if (c == ":") begin
              r[n] = mk(K_TOKEN, T_DCOL, FIELD_W'(start_q), FIELD_W'(2), 8'd0, 2'd0);
              n = n + 2'd1;
              mode_d = M_IDLE;
            end else begin
              r[n] = mk(K_TOKEN, T_COL, FIELD_W'(start_q), FIELD_W'(1), 8'd0, 2'd0);
              n = n + 2'd1;
              go = 1'b1;
            end
          end
          default: go = 1'b1;
        endcase
        if (go) begin
          mode_d  = M_IDLE;
          start_d = pos_q;
          if (c == " " || (c >= 8'd9 && c <= 8'd13)) mode_d = M_IDLE;
          else if (c == "/") mode_d = M_SLASH;
          else if (is_alpha(c)) begin
            alive_d = kw_next(7'h7F, c, 4'd0);
            mode_d  = M_IDENT;
          end else if (is_digit(c)) mode_d = M_INT;
          else if (c == "\"") mode_d = M_STR;
          else if (c == ":") mode_d = M_COLON;
          else if (pc != T_NONE) begin
            r[n] = mk(K_TOKEN, pc, FIELD_W'(pos_q), FIELD_W'(1), 8'd0, 2'd0);
            n = n + 2'd1;
          end else begin
            r[n] = mk(K_ERROR, T_NONE, FIELD_W'(pos_q), FIELD_W'(1), 8'd0, E_UNRECOG);
            n = n + 2'd1;
            mode_d = M_ERROR;
          end
        end
      end
    end
    if (n != 2'd0) r[n - 2'd1].last = 1'b1;
  end

  assign res_o.n     = n;
  assign res_o.items = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      alive_q <= '0;
    end else if (acc_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      alive_q <= alive_d;
    end
  end

endmodule

// ===== sv/stok_outbuf.sv =====
// ----------------------------------------------------------------------------
// stok_outbuf
// Result register holding up to three results of one byte, drained in order.
// ----------------------------------------------------------------------------
module stok_outbuf import stok_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  out_t [2:0] ent_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign ready_o     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_i.n;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= res_i.items;
    end else if (pop) begin
      ent_q <= {ent_q[2], ent_q[2:1]};
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
    else $error("load while results pending");
  a_load_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> cnt_q == $past(res_i.n))
    else $error("result count not loaded");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> cnt_q == 2'd1)
    else $error("last flag not on final result");

endmodule

// ===== sv/source_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer_top
// Streaming tokenizer: one source byte per transfer in, tokens out.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the result register can take it. Each
// byte yields zero to three results, which leave one per cycle, while the sink
// is ready, from a three-entry result register; a new byte is taken while the
// last pending result is being transferred, so with a ready sink the rate is one
// byte per cycle whenever bytes yield at most one result. The first result of a
// byte is available in the cycle after the byte transfer.
module source_tokenizer_top import stok_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  res_t res;
  logic acc;

  assign acc = in_valid_i && in_ready_o;

  stok_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .in_i   (in_data_i),
    .res_o  (res)
  );

  stok_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (acc),
    .res_i       (res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/source_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_top_tb
// Self-checking bench for the streaming source tokenizer. A short directed
// table is followed by random, mostly well-formed source text: keywords,
// identifiers, numbers, strings with escapes, comments, punctuation and
// colons, broken up by end-of-text markers and a little noise. Each result
// is compared field by field with the table's value where a row has one, or
// a bench token predictor, while both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------
module source_tokenizer_top_tb;
  import stok_pkg::*;

  typedef enum logic [3:0] {
    LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BSTAR, LX_IDENT, LX_INT,
    LX_INTDOT, LX_FLOAT, LX_STR, LX_ESC, LX_COLON, LX_ERROR
  } lex_e;

  typedef struct {
    in_t  d;
    bit   typed;
    out_t r;
  } row_t;

  localparam logic [23:0] POS_MAX = 24'hFFFFFF;
  localparam int          STALL_LIMIT = 1000;
  localparam string       PUNCT = "(){}[],=+-*/^.";

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  source_tokenizer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  string kw_text[7] = '{"if", "else", "for", "while", "namespace", "fn", "return"};

  lex_e        mode;
  logic [23:0] pos;
  logic [23:0] tok_start;
  logic [6:0]  kw_alive;
  out_t        batch[$];
  out_t        expected_tokens[$];
  row_t        stim[$];
  int          accepted_bytes;
  int          errors;
  bit          sender_done;
  bit          calm;
  bit          held_off;

  row_t plan[] = '{
    '{'{8'h00, 1'b1}, 1'b1, '{K_END, T_NONE, 24'd0, 24'd0, 8'd0, 2'd0, 1'b1}},
    '{'{"@", 1'b0}, 1'b1, '{K_ERROR, T_NONE, 24'd0, 24'd1, 8'd0, E_UNRECOG, 1'b1}},
    '{'{"a", 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b1, '{K_END, T_NONE, 24'd0, 24'd0, 8'd0, 2'd0, 1'b1}},
    '{'{"(", 1'b0}, 1'b1, '{K_TOKEN, 5'd11, 24'd0, 24'd1, 8'd0, 2'd0, 1'b1}},
    '{'{"7", 1'b0}, 1'b0, '0},
    '{'{".", 1'b0}, 1'b0, '0},
    '{'{"f", 1'b0}, 1'b0, '0},
    '{'{"n", 1'b0}, 1'b0, '0},
    '{'{"\"", 1'b0}, 1'b0, '0},
    '{'{"\\", 1'b0}, 1'b0, '0},
    '{'{"q", 1'b0}, 1'b0, '0},
    '{'{"\\", 1'b0}, 1'b0, '0},
    '{'{"n", 1'b0}, 1'b0, '0},
    '{'{"\"", 1'b0}, 1'b0, '0},
    '{'{"/", 1'b0}, 1'b0, '0},
    '{'{"*", 1'b0}, 1'b0, '0},
    '{'{"/", 1'b0}, 1'b0, '0},
    '{'{"*", 1'b0}, 1'b0, '0},
    '{'{"/", 1'b0}, 1'b0, '0},
    '{'{":", 1'b0}, 1'b0, '0},
    '{'{":", 1'b0}, 1'b0, '0},
    '{'{":", 1'b0}, 1'b0, '0},
    '{'{"\"", 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b0, '0}
  };

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic emit(logic [1:0] k, logic [4:0] t, logic [23:0] s, logic [23:0] l,
                      logic [7:0] cv, logic [1:0] e);
    out_t o;
    o = '{k, t, s, l, cv, e, 1'b0};
    if (batch.size() < 3) batch.insert(batch.size(), o);
  endtask

  task automatic kw_step(logic [7:0] c, logic [23:0] idx);
    for (int i = 0; i < 7; i++) begin
      if (kw_alive[i] && (idx >= kw_text[i].len() || kw_text[i][idx] != c)) begin
        kw_alive[i] = 1'b0;
      end
    end
  endtask

  task automatic flush_ident();
    logic [23:0] len;
    logic [4:0]  t;
    len = pos - tok_start;
    t = T_IDENT;
    for (int i = 6; i >= 0; i--) begin
      if (kw_alive[i] && len == kw_text[i].len()) t = 5'(i);
    end
    emit(K_TOKEN, t, tok_start, len, 8'd0, 2'd0);
  endtask

  task automatic open_token(logic [7:0] c);
    mode = LX_IDLE;
    tok_start = pos;
    if (is_space(c)) begin
      return;
    end else if (c == "/") begin
      mode = LX_SLASH;
    end else if (is_alpha(c)) begin
      kw_alive = 7'h7F;
      kw_step(c, 24'd0);
      mode = LX_IDENT;
    end else if (is_digit(c)) begin
      mode = LX_INT;
    end else if (c == "\"") begin
      mode = LX_STR;
    end else if (c == ":") begin
      mode = LX_COLON;
    end else begin
      for (int i = 0; i < 14; i++) begin
        if (PUNCT[i] == c) begin
          emit(K_TOKEN, 5'(11 + i), pos, 24'd1, 8'd0, 2'd0);
          return;
        end
      end
      emit(K_ERROR, T_NONE, pos, 24'd1, 8'd0, E_UNRECOG);
      mode = LX_ERROR;
    end
  endtask

  task automatic lex_byte(logic [7:0] c);
    logic [23:0] len;
    len = pos - tok_start;
    case (mode)
      LX_ERROR: ;
      LX_SLASH: begin
        if (c == "/") mode = LX_LINE;
        else if (c == "*") mode = LX_BLOCK;
        else begin
          emit(K_TOKEN, T_DIV, tok_start, 24'd1, 8'd0, 2'd0);
          open_token(c);
        end
      end
      LX_LINE: if (c == 8'd10) mode = LX_IDLE;
      LX_BLOCK: if (c == "*") mode = LX_BSTAR;
      LX_BSTAR: begin
        if (c == "/") mode = LX_IDLE;
        else if (c != "*") mode = LX_BLOCK;
      end
      LX_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") kw_step(c, len);
        else begin
          flush_ident();
          open_token(c);
        end
      end
      LX_INT: begin
        if (c == ".") mode = LX_INTDOT;
        else if (!is_digit(c)) begin
          emit(K_TOKEN, T_INT, tok_start, len, 8'd0, 2'd0);
          open_token(c);
        end
      end
      LX_INTDOT: begin
        if (is_digit(c)) mode = LX_FLOAT;
        else begin
          emit(K_TOKEN, T_INT, tok_start, len - 24'd1, 8'd0, 2'd0);
          emit(K_TOKEN, T_DOT, pos - 24'd1, 24'd1, 8'd0, 2'd0);
          open_token(c);
        end
      end
      LX_FLOAT: begin
        if (!is_digit(c)) begin
          emit(K_TOKEN, T_FLOAT, tok_start, len, 8'd0, 2'd0);
          open_token(c);
        end
      end
      LX_STR: begin
        if (c == "\"") begin
          emit(K_TOKEN, T_STRING, tok_start, len + 24'd1, 8'd0, 2'd0);
          mode = LX_IDLE;
        end else if (c == "\\") mode = LX_ESC;
        else emit(K_CHAR, T_NONE, 24'd0, 24'd0, c, 2'd0);
      end
      LX_ESC: begin
        if (c == "n") emit(K_CHAR, T_NONE, 24'd0, 24'd0, 8'd10, 2'd0);
        else if (c == "t") emit(K_CHAR, T_NONE, 24'd0, 24'd0, 8'd9, 2'd0);
        else if (c == "\"" || c == "\\") emit(K_CHAR, T_NONE, 24'd0, 24'd0, c, 2'd0);
        else begin
          emit(K_CHAR, T_NONE, 24'd0, 24'd0, "\\", 2'd0);
          emit(K_CHAR, T_NONE, 24'd0, 24'd0, c, 2'd0);
        end
        mode = LX_STR;
      end
      LX_COLON: begin
        if (c == ":") begin
          emit(K_TOKEN, T_DCOL, tok_start, 24'd2, 8'd0, 2'd0);
          mode = LX_IDLE;
        end else begin
          emit(K_TOKEN, T_COL, tok_start, 24'd1, 8'd0, 2'd0);
          open_token(c);
        end
      end
      default: open_token(c);
    endcase
  endtask

  task automatic end_text();
    logic [23:0] len;
    len = pos - tok_start;
    case (mode)
      LX_SLASH:  emit(K_TOKEN, T_DIV, tok_start, 24'd1, 8'd0, 2'd0);
      LX_IDENT:  flush_ident();
      LX_INT:    emit(K_TOKEN, T_INT, tok_start, len, 8'd0, 2'd0);
      LX_FLOAT:  emit(K_TOKEN, T_FLOAT, tok_start, len, 8'd0, 2'd0);
      LX_INTDOT: begin
        emit(K_TOKEN, T_INT, tok_start, len - 24'd1, 8'd0, 2'd0);
        emit(K_TOKEN, T_DOT, pos - 24'd1, 24'd1, 8'd0, 2'd0);
      end
      LX_COLON:  emit(K_TOKEN, T_COL, tok_start, 24'd1, 8'd0, 2'd0);
      LX_STR, LX_ESC: emit(K_ERROR, T_NONE, tok_start, len, 8'd0, E_UNTERM);
      default: ;
    endcase
    emit(K_END, T_NONE, 24'd0, 24'd0, 8'd0, 2'd0);
    mode = LX_IDLE;
    pos = '0;
    tok_start = '0;
    kw_alive = '0;
  endtask

  // Fill batch with the results that one transfer causes.
  task automatic predict_tokens(in_t d);
    batch.delete();
    if (d.end_of_text) begin
      end_text();
    end else if (mode != LX_ERROR) begin
      if (pos == POS_MAX) begin
        emit(K_ERROR, T_NONE, POS_MAX, 24'd0, 8'd0, E_TOOLONG);
        mode = LX_ERROR;
      end else begin
        lex_byte(d.ch);
        pos = pos + 24'd1;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
  endtask

  task automatic put(logic [7:0] c, bit eot = 1'b0);
    row_t r;
    r.d = '{c, eot};
    r.typed = 1'b0;
    r.r = '0;
    stim.insert(stim.size(), r);
  endtask

  function automatic logic [7:0] any_alpha();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? "a" + c : "A" + c;
  endfunction

  function automatic logic [7:0] any_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  task automatic put_digits(int n);
    for (int i = 0; i < n; i++) put(any_digit());
  endtask

  // Append one lexical element of random content.
  task automatic gen_element();
    logic [7:0] c;
    int k;
    case ($urandom_range(0, 12))
      0: begin
        k = $urandom_range(0, 6);
        for (int i = 0; i < kw_text[k].len(); i++) put(kw_text[k][i]);
        if ($urandom_range(0, 3) == 0) put("_");
      end
      1: begin
        put(any_alpha());
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 2))
            0: put(any_alpha());
            1: put(any_digit());
            default: put("_");
          endcase
        end
      end
      2: put_digits($urandom_range(1, 4));
      3: begin
        put_digits($urandom_range(1, 3));
        put(".");
        put_digits($urandom_range(1, 3));
      end
      4: begin
        put_digits($urandom_range(1, 3));
        put(".");
      end
      5, 6: begin
        put("\"");
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 2) == 0) begin
            put("\\");
            case ($urandom_range(0, 4))
              0: put("n");
              1: put("t");
              2: put("\"");
              3: put("\\");
              default: put(8'($urandom_range(0, 255)));
            endcase
          end else begin
            c = 8'($urandom_range(32, 126));
            put(c == "\"" || c == "\\" ? "x" : c);
          end
        end
        if ($urandom_range(0, 9) != 0) put("\"");
      end
      7: begin
        put("/");
        put("/");
        repeat ($urandom_range(0, 5)) put(8'($urandom_range(32, 126)));
        put(8'd10);
      end
      8: begin
        put("/");
        put("*");
        repeat ($urandom_range(0, 5)) put($urandom_range(0, 2) ? "*" : "/");
        put("*");
        put("/");
      end
      9: put(PUNCT[$urandom_range(0, 13)]);
      10: begin
        put(":");
        if ($urandom_range(0, 1)) put(":");
      end
      11: put($urandom_range(0, 4) ? " " : 8'($urandom_range(9, 13)));
      default: if ($urandom_range(0, 3) == 0) put(8'($urandom_range(0, 255)));
        else put(" ");
    endcase
    if ($urandom_range(0, 1)) put(" ");
  endtask

  function automatic bit same(out_t a, out_t b);
    return a === b;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus.
  initial begin
    int gap;
    in_valid = 1'b0;
    in_data = '0;
    sender_done = 1'b0;
    foreach (plan[i]) stim.insert(stim.size(), plan[i]);
    while (stim.size() < 250) begin
      gen_element();
      if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)), 1'b1);
    end
    put(8'h00, 1'b1);
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (int i = 0; i < stim.size(); i++) begin
      calm = (stim.size() - i) < 40;
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= stim[i].d;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Sink with random stalls and one long hold-off.
  initial begin
    out_ready = 1'b0;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && accepted_bytes >= 60) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Predict on each byte transfer, check on each result transfer.
  initial begin
    int idx;
    out_t want;
    idx = 0;
    errors = 0;
    accepted_bytes = 0;
    mode = LX_IDLE;
    pos = '0;
    tok_start = '0;
    kw_alive = '0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          want = expected_tokens[0];
          expected_tokens.delete(0);
          if (!same(want, out_data)) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            errors++;
          end
        end
      end
      if (rst_n && in_valid && in_ready) begin
        predict_tokens(stim[idx].d);
        if (stim[idx].typed) begin
          expected_tokens.insert(expected_tokens.size(), stim[idx].r);
        end else begin
          foreach (batch[j]) expected_tokens.insert(expected_tokens.size(), batch[j]);
        end
        idx++;
        accepted_bytes++;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    wait (sender_done);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
